/* rtl/core/miu_pkg.sv */
// Package: request/response types, sizes, status codes and microcode ROM of the inverse unit.
package miu_pkg;

  localparam int unsigned EXP_W     = 16;
  localparam int unsigned MOD_W     = 32;
  localparam int unsigned MAX_STEPS = 48;
  localparam int unsigned STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int unsigned CNT_W     = $clog2(MOD_W);
  localparam int unsigned PC_W      = 4;
  localparam int unsigned ST_W      = 2;

  typedef logic [ST_W-1:0] status_t;
  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_NO_INVERSE = 2'd1;
  localparam status_t ST_BAD_MOD    = 2'd2;

  typedef struct packed {
    logic [EXP_W-1:0] exponent;
    logic [MOD_W-1:0] modulus;
  } req_t;

  typedef struct packed {
    logic [MOD_W-1:0] inverse;
    status_t          status;
  } rsp_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT_A,
    OP_DIV_STEP,
    OP_EUCLID_INIT,
    OP_DIV_INIT_R,
    OP_EUCLID_UPD,
    OP_REDUCE,
    OP_FINAL,
    OP_BAD_MOD,
    OP_NO_INV,
    OP_EMIT
  } op_e;

  // Sequencing: next, jump, branch (taken or fall through), wait (taken or stay)
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_BRANCH,
    SEQ_WAIT
  } seq_e;

  typedef enum logic [2:0] {
    COND_IN_VALID,
    COND_MOD_SMALL,
    COND_DIV_LAST,
    COND_EUCLID_DONE,
    COND_NO_INV,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e             op;
    seq_e            seq;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] PC_CHK       = 4'd1;
  localparam logic [PC_W-1:0] PC_DIVA      = 4'd2;
  localparam logic [PC_W-1:0] PC_DIVA_LOOP = 4'd3;
  localparam logic [PC_W-1:0] PC_EINIT     = 4'd4;
  localparam logic [PC_W-1:0] PC_TEST      = 4'd5;
  localparam logic [PC_W-1:0] PC_DIVR      = 4'd6;
  localparam logic [PC_W-1:0] PC_DIVR_LOOP = 4'd7;
  localparam logic [PC_W-1:0] PC_UPD       = 4'd8;
  localparam logic [PC_W-1:0] PC_FIN       = 4'd9;
  localparam logic [PC_W-1:0] PC_RED       = 4'd10;
  localparam logic [PC_W-1:0] PC_FINAL     = 4'd11;
  localparam logic [PC_W-1:0] PC_BADM      = 4'd12;
  localparam logic [PC_W-1:0] PC_NOINV     = 4'd13;
  localparam logic [PC_W-1:0] PC_EMIT      = 4'd14;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    unique case (pc)
      PC_IDLE:      w = '{op: OP_LOAD,        seq: SEQ_WAIT,   cond: COND_IN_VALID,
                          target: PC_CHK};
      PC_CHK:       w = '{op: OP_NOP,         seq: SEQ_BRANCH, cond: COND_MOD_SMALL,
                          target: PC_BADM};
      PC_DIVA:      w = '{op: OP_DIV_INIT_A,  seq: SEQ_NEXT,   cond: COND_DIV_LAST,
                          target: PC_IDLE};
      PC_DIVA_LOOP: w = '{op: OP_DIV_STEP,    seq: SEQ_WAIT,   cond: COND_DIV_LAST,
                          target: PC_EINIT};
      PC_EINIT:     w = '{op: OP_EUCLID_INIT, seq: SEQ_NEXT,   cond: COND_DIV_LAST,
                          target: PC_IDLE};
      PC_TEST:      w = '{op: OP_NOP,         seq: SEQ_BRANCH, cond: COND_EUCLID_DONE,
                          target: PC_FIN};
      PC_DIVR:      w = '{op: OP_DIV_INIT_R,  seq: SEQ_NEXT,   cond: COND_DIV_LAST,
                          target: PC_IDLE};
      PC_DIVR_LOOP: w = '{op: OP_DIV_STEP,    seq: SEQ_WAIT,   cond: COND_DIV_LAST,
                          target: PC_UPD};
      PC_UPD:       w = '{op: OP_EUCLID_UPD,  seq: SEQ_JUMP,   cond: COND_DIV_LAST,
                          target: PC_TEST};
      PC_FIN:       w = '{op: OP_NOP,         seq: SEQ_BRANCH, cond: COND_NO_INV,
                          target: PC_NOINV};
      PC_RED:       w = '{op: OP_REDUCE,      seq: SEQ_NEXT,   cond: COND_DIV_LAST,
                          target: PC_IDLE};
      PC_FINAL:     w = '{op: OP_FINAL,       seq: SEQ_JUMP,   cond: COND_DIV_LAST,
                          target: PC_EMIT};
      PC_BADM:      w = '{op: OP_BAD_MOD,     seq: SEQ_JUMP,   cond: COND_DIV_LAST,
                          target: PC_EMIT};
      PC_NOINV:     w = '{op: OP_NO_INV,      seq: SEQ_JUMP,   cond: COND_DIV_LAST,
                          target: PC_EMIT};
      PC_EMIT:      w = '{op: OP_EMIT,        seq: SEQ_WAIT,   cond: COND_OUT_FREE,
                          target: PC_IDLE};
      default:      w = '{op: OP_NOP,         seq: SEQ_JUMP,   cond: COND_DIV_LAST,
                          target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/modular_inverse_unit_core.sv */
// Top level: microcoded extended-Euclid modular inverse unit.
// Latency grows with the number k of Euclid steps (k <= 46 for a 32-bit modulus); a modulus
//   below two skips the divider and goes straight to the response.
// One request at a time; each Euclid step is paced by the serial divider.
// A new request is taken while the previous response still waits in the output register.
// Reset (rst_ni low, async) returns the sequencer to idle and empties the output register.
module modular_inverse_unit_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  miu_pkg::req_t     in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output miu_pkg::rsp_t     out_rsp_o
);

  localparam int unsigned W = miu_pkg::MOD_W;

  // Sequencer
  logic [miu_pkg::PC_W-1:0] pc_q, pc_d;
  miu_pkg::ctl_t            ctl;
  logic                     cond;

  // Operand and Euclid registers
  logic [miu_pkg::EXP_W-1:0] a_q;
  logic [W-1:0]              m_q;
  logic [W-1:0]              prev_r_q, cur_r_q;
  logic [W-1:0]              prev_mag_q, cur_mag_q;
  logic                      prev_neg_q, cur_neg_q;
  logic [miu_pkg::STEP_W-1:0] steps_q;

  // Serial divider with fused quotient-times-coefficient accumulator
  logic [W-1:0]              dvd_q, dvs_q, rem_q, acc_q;
  logic [miu_pkg::CNT_W-1:0] cnt_q;
  logic [W:0]                trial, diff;
  logic                      fits;
  logic [W-1:0]              rem_step, acc_step;

  // Result staging and output register
  logic [W-1:0]              res_inv_q;
  miu_pkg::status_t          res_status_q;
  logic                      out_valid_q;
  miu_pkg::rsp_t             out_rsp_q;
  logic                      out_free, in_take, emit;

  assign ctl        = miu_pkg::ucode(pc_q);
  assign in_stall_o = (ctl.op != miu_pkg::OP_LOAD);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (ctl.op == miu_pkg::OP_EMIT) && out_free;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Restoring divide step; the accumulator runs Horner on the quotient bits, MSB first,
  // so it ends holding quotient times the current coefficient magnitude.
  always_comb begin
    trial    = {rem_q, dvd_q[W-1]};
    diff     = trial - {1'b0, dvs_q};
    fits     = (trial >= {1'b0, dvs_q});
    rem_step = fits ? diff[W-1:0] : trial[W-1:0];
    acc_step = {acc_q[W-2:0], 1'b0} + (fits ? cur_mag_q : '0);
  end

  // Branch conditions
  always_comb begin
    unique case (ctl.cond)
      miu_pkg::COND_IN_VALID:    cond = in_valid_i;
      miu_pkg::COND_MOD_SMALL:   cond = (m_q[W-1:1] == '0);
      miu_pkg::COND_DIV_LAST:    cond = (cnt_q == '0);
      miu_pkg::COND_EUCLID_DONE: cond = (cur_r_q == '0) ||
                                        (steps_q == miu_pkg::STEP_W'(miu_pkg::MAX_STEPS));
      miu_pkg::COND_NO_INV:      cond = (cur_r_q != '0) || (prev_r_q != W'(1));
      miu_pkg::COND_OUT_FREE:    cond = out_free;
      default:                   cond = 1'b0;
    endcase
  end

  // Next program address
  always_comb begin
    unique case (ctl.seq)
      miu_pkg::SEQ_NEXT:   pc_d = pc_q + 1'b1;
      miu_pkg::SEQ_JUMP:   pc_d = ctl.target;
      miu_pkg::SEQ_BRANCH: pc_d = cond ? ctl.target : pc_q + 1'b1;
      miu_pkg::SEQ_WAIT:   pc_d = cond ? ctl.target : pc_q;
      default:             pc_d = miu_pkg::PC_IDLE;
    endcase
  end

  // Control state: program counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= miu_pkg::PC_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath driven by the current control word
  always_ff @(posedge clk_i) begin
    unique case (ctl.op)
      miu_pkg::OP_LOAD: begin
        if (in_take) begin
          a_q <= in_req_i.exponent;
          m_q <= in_req_i.modulus;
        end
      end
      miu_pkg::OP_DIV_INIT_A: begin
        // reduce the exponent modulo the modulus first
        dvd_q <= W'(a_q);
        dvs_q <= m_q;
        rem_q <= '0;
        acc_q <= '0;
        cnt_q <= miu_pkg::CNT_W'(W - 1);
      end
      miu_pkg::OP_DIV_STEP: begin
        dvd_q <= {dvd_q[W-2:0], 1'b0};
        rem_q <= rem_step;
        acc_q <= acc_step;
        cnt_q <= cnt_q - 1'b1;
      end
      miu_pkg::OP_EUCLID_INIT: begin
        prev_r_q   <= m_q;
        cur_r_q    <= rem_q;
        prev_mag_q <= '0;
        cur_mag_q  <= W'(1);
        prev_neg_q <= 1'b0;
        cur_neg_q  <= 1'b0;
        steps_q    <= '0;
      end
      miu_pkg::OP_DIV_INIT_R: begin
        dvd_q <= prev_r_q;
        dvs_q <= cur_r_q;
        rem_q <= '0;
        acc_q <= '0;
        cnt_q <= miu_pkg::CNT_W'(W - 1);
      end
      miu_pkg::OP_EUCLID_UPD: begin
        // advance remainders and coefficient magnitudes; signs alternate
        prev_r_q   <= cur_r_q;
        cur_r_q    <= rem_q;
        prev_mag_q <= cur_mag_q;
        cur_mag_q  <= prev_mag_q + acc_q;
        prev_neg_q <= cur_neg_q;
        cur_neg_q  <= !cur_neg_q;
        steps_q    <= steps_q + 1'b1;
      end
      miu_pkg::OP_REDUCE: begin
        if (prev_mag_q >= m_q) begin
          prev_mag_q <= prev_mag_q - m_q;
        end
      end
      miu_pkg::OP_FINAL: begin
        // fold a negative coefficient back into 0..m-1
        res_inv_q    <= (prev_neg_q && (prev_mag_q != '0)) ? m_q - prev_mag_q : prev_mag_q;
        res_status_q <= miu_pkg::ST_OK;
      end
      miu_pkg::OP_BAD_MOD: begin
        res_inv_q    <= '0;
        res_status_q <= miu_pkg::ST_BAD_MOD;
      end
      miu_pkg::OP_NO_INV: begin
        res_inv_q    <= '0;
        res_status_q <= miu_pkg::ST_NO_INVERSE;
      end
      miu_pkg::OP_EMIT: begin
        if (out_free) begin
          out_rsp_q.inverse <= res_inv_q;
          out_rsp_q.status  <= res_status_q;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  // An accepted request always starts with the modulus check.
  a_take_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> pc_q == miu_pkg::PC_CHK)
    else $error("request accepted but sequencer did not start");

  // The divider never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == miu_pkg::PC_DIVA_LOOP || pc_q == miu_pkg::PC_DIVR_LOOP) |-> dvs_q != '0)
    else $error("divide step with zero divisor");

  // A successful inverse lies below the modulus.
  a_inv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == miu_pkg::PC_EMIT && res_status_q == miu_pkg::ST_OK) |-> res_inv_q < m_q)
    else $error("inverse not reduced below modulus");

  // A failing status carries a zero inverse.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status != miu_pkg::ST_OK) |-> out_rsp_o.inverse == '0)
    else $error("nonzero inverse with failing status");

  // The Euclid step count stays within its limit.
  a_step_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == miu_pkg::PC_UPD) |-> steps_q < miu_pkg::STEP_W'(miu_pkg::MAX_STEPS))
    else $error("Euclid step limit exceeded");
`endif

endmodule

/* test/tb_modular_inverse_unit_core.sv */
`timescale 1ns / 100ps
// Testbench: checks modular_inverse_unit_core responses against an extended-Euclid predictor.
module tb_modular_inverse_unit_core;

  // Row of the directed table; has_rsp marks rows whose response is typed in by hand.
  typedef struct {
    miu_pkg::req_t req;
    bit            has_rsp;
    miu_pkg::rsp_t rsp;
  } inverse_row_t;

  localparam int unsigned NUM_ROWS   = 16;
  localparam int unsigned NUM_RANDOM = 370;
  localparam int unsigned IDLE_PCT   = 13;
  localparam int unsigned DRAIN_CYC  = 40;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  miu_pkg::req_t in_req_i    = '0;
  logic          out_stall_i = 1'b0;
  logic          in_stall_o;
  logic          out_valid_o;
  miu_pkg::rsp_t out_rsp_o;

  // Set during the burst where neither side idles.
  bit            steady = 1'b0;
  int            error_count = 0;
  miu_pkg::rsp_t inverse_q[$];

  inverse_row_t directed_rows[NUM_ROWS];

  modular_inverse_unit_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Extended Euclid on the remainders (modulus, exponent mod modulus); the exponent's
  // coefficient is kept as a magnitude with a sign that flips every step.
  function automatic miu_pkg::rsp_t predict_inverse(input miu_pkg::req_t r);
    miu_pkg::rsp_t res;
    logic [63:0]   m, rem_prev, rem_cur, rem_next, mag_prev, mag_cur, mag_next, quot;
    bit            neg_prev, neg_cur;
    int            steps;
    res = '0;
    m   = 64'(r.modulus);
    if (m < 64'd2) begin
      res.status = miu_pkg::ST_BAD_MOD;
      return res;
    end
    rem_prev = m;
    rem_cur  = 64'(r.exponent) % m;
    mag_prev = 64'd0;
    mag_cur  = 64'd1;
    neg_prev = 1'b0;
    neg_cur  = 1'b0;
    for (steps = 0; steps < miu_pkg::MAX_STEPS && rem_cur != 64'd0; steps++) begin
      quot     = rem_prev / rem_cur;
      rem_next = rem_prev - quot * rem_cur;
      mag_next = mag_prev + quot * mag_cur;
      rem_prev = rem_cur;
      rem_cur  = rem_next;
      mag_prev = mag_cur;
      mag_cur  = mag_next;
      neg_prev = neg_cur;
      neg_cur  = !neg_cur;
    end
    // Leftover remainder (step limit) or gcd other than one: no inverse.
    if (rem_cur != 64'd0 || rem_prev != 64'd1) begin
      res.status = miu_pkg::ST_NO_INVERSE;
      return res;
    end
    mag_prev    = mag_prev % m;
    res.inverse = (neg_prev && mag_prev != 64'd0) ? miu_pkg::MOD_W'(m - mag_prev)
                                                  : miu_pkg::MOD_W'(mag_prev);
    res.status  = miu_pkg::ST_OK;
    return res;
  endfunction

  // Mix of bad moduli, multiples, small and RSA-like moduli, and fully random words.
  function automatic miu_pkg::req_t random_request();
    miu_pkg::req_t r;
    int unsigned   kind;
    kind       = $urandom_range(99);
    r.exponent = miu_pkg::EXP_W'($urandom);
    r.modulus  = $urandom;
    if (kind < 5) begin
      r.modulus = miu_pkg::MOD_W'($urandom_range(1));
    end else if (kind < 12) begin
      // exponent a multiple of a small modulus: gcd is the modulus
      r.modulus  = miu_pkg::MOD_W'($urandom_range(255, 2));
      r.exponent = miu_pkg::EXP_W'(r.modulus * $urandom_range(255));
    end else if (kind < 32) begin
      r.modulus = miu_pkg::MOD_W'($urandom_range(1000, 2));
    end else if (kind < 45) begin
      r.modulus = miu_pkg::MOD_W'($urandom_range(65535, 2));
    end else if (kind < 75) begin
      // totient-like even modulus with a typical odd public exponent
      r.modulus  = {$urandom} | 32'h8000_0000;
      r.modulus[0] = 1'b0;
      case ($urandom_range(3))
        0:       r.exponent = 16'd3;
        1:       r.exponent = 16'd17;
        2:       r.exponent = 16'd257;
        default: r.exponent = miu_pkg::EXP_W'($urandom) | 16'h0001;
      endcase
    end
    return r;
  endfunction

  // Drive one request from a falling edge; return at the falling edge after acceptance.
  task automatic push_request(input miu_pkg::req_t r, input miu_pkg::rsp_t expected_rsp);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    inverse_q.push_back(expected_rsp);
    @(negedge clk_i);
  endtask

  // Stall the response side at random, except during the steady burst.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Compare each accepted response with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected response inverse=%0d status=%0d", $time,
                 out_rsp_o.inverse, out_rsp_o.status);
        error_count++;
      end else begin
        if (out_rsp_o.inverse !== inverse_q[0].inverse) begin
          $display("%0t: inverse mismatch: expected %0d, actual %0d", $time,
                   inverse_q[0].inverse, out_rsp_o.inverse);
          error_count++;
        end
        if (out_rsp_o.status !== inverse_q[0].status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   inverse_q[0].status, out_rsp_o.status);
          error_count++;
        end
        void'(inverse_q.pop_front());
      end
    end
  end

  initial begin
    miu_pkg::req_t r;
    miu_pkg::rsp_t rsp;
    int unsigned   waited;

    directed_rows = '{
      // modulus below two
      '{'{16'd0,     32'd0},           1'b1, '{32'd0,     miu_pkg::ST_BAD_MOD}},
      '{'{16'hFFFF,  32'd1},           1'b1, '{32'd0,     miu_pkg::ST_BAD_MOD}},
      // exponent zero, or a multiple of the modulus: gcd is the modulus
      '{'{16'd0,     32'd7},           1'b1, '{32'd0,     miu_pkg::ST_NO_INVERSE}},
      '{'{16'd0,     32'd2},           1'b1, '{32'd0,     miu_pkg::ST_NO_INVERSE}},
      '{'{16'd12,    32'd6},           1'b1, '{32'd0,     miu_pkg::ST_NO_INVERSE}},
      '{'{16'hFFFF,  32'hFFFF},        1'b1, '{32'd0,     miu_pkg::ST_NO_INVERSE}},
      // gcd above one without being the modulus
      '{'{16'd6,     32'd9},           1'b1, '{32'd0,     miu_pkg::ST_NO_INVERSE}},
      '{'{16'd3,     32'hFFFF_FFFF},   1'b1, '{32'd0,     miu_pkg::ST_NO_INVERSE}},
      '{'{16'h8000,  32'h8000_0000},   1'b1, '{32'd0,     miu_pkg::ST_NO_INVERSE}},
      // plain inverses
      '{'{16'd1,     32'd2},           1'b1, '{32'd1,     miu_pkg::ST_OK}},
      '{'{16'd17,    32'd3120},        1'b0, '{32'd0,     miu_pkg::ST_OK}},
      '{'{16'hFFFF,  32'h1_0000},      1'b1, '{32'hFFFF,  miu_pkg::ST_OK}},
      '{'{16'd1,     32'hFFFF_FFFF},   1'b1, '{32'd1,     miu_pkg::ST_OK}},
      // exponent not below the modulus, long Fibonacci chain, widest operands
      '{'{16'd100,   32'd7},           1'b0, '{32'd0,     miu_pkg::ST_OK}},
      '{'{16'd46368, 32'd75025},       1'b0, '{32'd0,     miu_pkg::ST_OK}},
      '{'{16'hFFFF,  32'hFFFF_FFFE},   1'b0, '{32'd0,     miu_pkg::ST_OK}}
    };

    // Hold reset, then release it on a falling edge.
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      rsp = directed_rows[i].has_rsp ? directed_rows[i].rsp
                                     : predict_inverse(directed_rows[i].req);
      push_request(directed_rows[i].req, rsp);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // Run a burst with no idling on either side.
      steady = (n >= 120 && n < 200);
      r = random_request();
      push_request(r, predict_inverse(r));
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    // Drain outstanding responses, then watch a little longer for stray ones.
    waited = 0;
    while (inverse_q.size() != 0 && waited < 200000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYC) @(negedge clk_i);

    if (error_count == 0 && inverse_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Bound the run well above the slowest legal case.
  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
